>>> hw/rtl/tvas_pkg.sv
// Package for the two-voice audio synth core: widths, register indexes,
// rate-scaling and noise constants, and the noise register step function.
// No dependencies.
package tvas_pkg;

    localparam int PITCH_W  = 16;
    localparam int VOL_W    = 8;
    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // floor(pitch*262/735) == (pitch*RATE_MUL) >> RATE_SHIFT for every 16-bit pitch
    localparam int RATE_MUL_W = 25;
    localparam logic [RATE_MUL_W-1:0] RATE_MUL = 25'd23921800;
    localparam int RATE_SHIFT = 26;
    localparam int RATE_PROD_W = PITCH_W + RATE_MUL_W;

    localparam int GAIN_SHIFT = 10;

    localparam logic [15:0] NOISE_TAPS = 16'hB400;
    localparam logic [15:0] NOISE_SEED = 16'hACE1;

    localparam logic [CFG_IDX_W-1:0] CFG_V1_PITCH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V1_VOLUME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V1_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V2_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V2_VOLUME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V2_NOISE  = 3'd5;

    function automatic logic [15:0] lfsr_step(input logic [15:0] r);
        logic [15:0] s;
        s = {1'b0, r[15:1]};
        if (r[0]) begin
            s = s ^ NOISE_TAPS;
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/tvas_voice.sv
// One synth voice: registered phase increment, phase accumulator and the
// sawtooth/noise gain stage. Uses tvas_pkg.
module tvas_voice (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_advance,
    input  logic [tvas_pkg::PITCH_W-1:0]       i_pitch,
    input  logic [tvas_pkg::VOL_W-1:0]         i_volume,
    input  logic                               i_noise,
    input  logic [15:0]                        i_lfsr,
    output logic [15:0]                        o_lfsr,
    output logic signed [tvas_pkg::SAMPLE_W-1:0] o_value
);
    import tvas_pkg::*;

    logic [PHASE_W-1:0]      r_inc;
    logic [PHASE_W-1:0]      n_inc;
    logic [PHASE_W-1:0]      r_phase;
    logic [PHASE_W-1:0]      n_phase;
    logic [RATE_PROD_W-1:0]  inc_prod;
    logic [15:0]             lfsr_next;
    logic signed [16:0]      gain_opnd;
    logic signed [25:0]      gain_prod;

    // increment is registered from the pitch register and follows it in the next cycle
    assign inc_prod = RATE_PROD_W'(i_pitch) * RATE_PROD_W'(RATE_MUL);
    assign n_inc    = PHASE_W'(inc_prod[RATE_PROD_W-1:RATE_SHIFT]);
    assign n_phase  = r_phase + r_inc;
    assign lfsr_next = lfsr_step(i_lfsr);

    assign gain_opnd = i_noise ? $signed({1'b0, lfsr_next})
                               : $signed({n_phase[PHASE_W-1], n_phase});
    assign gain_prod = 26'(gain_opnd) * 26'($signed({1'b0, i_volume}));
    assign o_value   = gain_prod[GAIN_SHIFT +: SAMPLE_W];
    assign o_lfsr    = i_noise ? lfsr_next : i_lfsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= '0;
            r_phase <= '0;
        end else begin
            r_inc <= n_inc;
            if (i_advance) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

>>> hw/rtl/two_voice_audio_synth_core.sv
// Top level of the two-voice audio synth: config registers, tick input
// register, noise register, mixer, low-pass filter and output register.
// Uses tvas_pkg and tvas_voice.

// One tick beat in gives one 16-bit signed sample beat out, one beat per clock
// sustained while the output is not stalled; an accepted tick goes through the
// input register, then a single combinational pass through voice gain
// multiply, mix and filter into the output register. A pitch write takes
// effect for ticks accepted from the cycle after the write on, since the
// rate-scaled phase increment is registered. The config port is always ready.
module two_voice_audio_synth_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tvas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvas_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_buffer_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [tvas_pkg::SAMPLE_W-1:0] o_sample
);
    import tvas_pkg::*;

    logic [PITCH_W-1:0] r_v1_pitch;
    logic [VOL_W-1:0]   r_v1_volume;
    logic               r_v1_noise;
    logic [PITCH_W-1:0] r_v2_pitch;
    logic [VOL_W-1:0]   r_v2_volume;
    logic               r_v2_noise;

    logic r_in_valid;
    logic n_in_valid;
    logic r_in_start;
    logic r_out_valid;
    logic n_out_valid;
    logic [15:0] r_lfsr;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] n_sample;

    logic in_accept;
    logic advance;
    logic [15:0] lfsr_mid;
    logic [15:0] lfsr_end;
    logic signed [SAMPLE_W-1:0] v1_value;
    logic signed [SAMPLE_W-1:0] v2_value;
    logic signed [SAMPLE_W-1:0] mix;
    logic signed [SAMPLE_W+2:0] mix7;
    logic signed [SAMPLE_W+2:0] mix7_q;
    logic signed [SAMPLE_W:0]   prev_q;
    logic signed [SAMPLE_W:0]   filt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_pitch  <= '0;
            r_v1_volume <= '0;
            r_v1_noise  <= 1'b0;
            r_v2_pitch  <= '0;
            r_v2_volume <= '0;
            r_v2_noise  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_V1_PITCH:  r_v1_pitch  <= i_cfg_data[PITCH_W-1:0];
                CFG_V1_VOLUME: r_v1_volume <= i_cfg_data[VOL_W-1:0];
                CFG_V1_NOISE:  r_v1_noise  <= i_cfg_data[0];
                CFG_V2_PITCH:  r_v2_pitch  <= i_cfg_data[PITCH_W-1:0];
                CFG_V2_VOLUME: r_v2_volume <= i_cfg_data[VOL_W-1:0];
                CFG_V2_NOISE:  r_v2_noise  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign n_in_valid = in_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = advance ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);

    tvas_voice u_voice1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pitch   (r_v1_pitch),
        .i_volume  (r_v1_volume),
        .i_noise   (r_v1_noise),
        .i_lfsr    (r_lfsr),
        .o_lfsr    (lfsr_mid),
        .o_value   (v1_value)
    );

    tvas_voice u_voice2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pitch   (r_v2_pitch),
        .i_volume  (r_v2_volume),
        .i_noise   (r_v2_noise),
        .i_lfsr    (lfsr_mid),
        .o_lfsr    (lfsr_end),
        .o_value   (v2_value)
    );

    // mix and one-pole low-pass (bypassed on a buffer-start tick), divisions truncate toward zero
    assign mix    = v1_value + v2_value;
    assign mix7   = ($signed({{3{mix[SAMPLE_W-1]}}, mix}) <<< 3)
                    - $signed({{3{mix[SAMPLE_W-1]}}, mix});
    assign mix7_q = $signed(mix7 + (mix7[SAMPLE_W+2] ? (SAMPLE_W+3)'(7) : '0)) >>> 3;
    assign prev_q = $signed({r_sample[SAMPLE_W-1], r_sample}
                            + (r_sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(7) : '0)) >>> 3;
    assign filt   = mix7_q[SAMPLE_W:0] + prev_q;
    assign n_sample = r_in_start ? mix : filt[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lfsr      <= NOISE_SEED;
            r_sample    <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_lfsr   <= lfsr_end;
                r_sample <= n_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_start <= i_buffer_start;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule
